// ----- src/huffman_decode_table_assert.svh -----
// ----------------------------------------------------------------------------
// Huffman decode table assertion macros
// Shorthand for clocked, reset-qualified property checks.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_DECODE_TABLE_ASSERT_SVH
`define HUFFMAN_DECODE_TABLE_ASSERT_SVH

// same-cycle implication
`define HDT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HDT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/hdt_pkg.sv -----
// ----------------------------------------------------------------------------
// Huffman decode table package
// Shared field widths, codes, state and status types.
// ----------------------------------------------------------------------------
package hdt_pkg;

    localparam int CODE_BITS_DEF   = 10;
    localparam int SYMBOL_BITS_DEF = 8;

    localparam int KEY_W      = 10;
    localparam int LEN_W      = 4;
    localparam int SYM_IO_W   = 8;
    localparam int FUNC_W     = 2;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOOKUP = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_WRITE  = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_FILL   = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_INIT = 2'd0,
        ST_IDLE = 2'd1,
        ST_READ = 2'd2,
        ST_FILL = 2'd3
    } state_t;

    typedef struct packed {
        logic init_done;
        logic busy;
    } status_t;

endpackage

// ----- src/huffman_decode_table.sv -----
// Lookup: queue slot, table read, result register; no new command in ST_READ.
// Raw write: a single table write in ST_FILL; rejected insert: a result word only.
// Insert of length L: 2^(CODE_BITS-L) table writes, one table write per cycle.
// Clear: writes all entries; the single table write port sets all sweep rates.
// Reset: a pass clearing all 2^CODE_BITS entries runs first; s_tready stays low.
// ----------------------------------------------------------------------------
// Huffman decode table
// Direct-indexed decode table with lookup, code insert, raw write and clear.
// ----------------------------------------------------------------------------
`include "huffman_decode_table_assert.svh"

module huffman_decode_table #(
    parameter int CODE_BITS   = hdt_pkg::CODE_BITS_DEF,
    parameter int SYMBOL_BITS = hdt_pkg::SYMBOL_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // key_or_code[9:0], code_length[13:10], symbol[21:14], zero fill
    input  logic [hdt_pkg::S_TDATA_W-1:0] s_tdata,
    // func[1:0]
    input  logic [hdt_pkg::FUNC_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // found[0], out_symbol[8:1], out_length[12:9], accepted[13], zero fill
    output logic [hdt_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int CMD_W = 2 + 2 * CODE_BITS + 1 + hdt_pkg::LEN_W + SYMBOL_BITS;

    hdt_pkg::status_t  status;
    logic              q_push;
    logic [CMD_W-1:0]  q_in_data;
    logic              q_ready;
    logic              q_pop;
    logic [CMD_W-1:0]  q_out_data;
    logic              q_valid;

    hdt_front #(
        .CODE_BITS   (CODE_BITS),
        .SYMBOL_BITS (SYMBOL_BITS),
        .CMD_W       (CMD_W)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .status   (status),
        .q_push   (q_push),
        .q_data   (q_in_data),
        .q_ready  (q_ready)
    );

    hdt_queue #(
        .WIDTH (CMD_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in_data),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_data   (q_out_data),
        .pop_valid  (q_valid)
    );

    hdt_back #(
        .CODE_BITS   (CODE_BITS),
        .SYMBOL_BITS (SYMBOL_BITS),
        .CMD_W       (CMD_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_out_data),
        .q_pop    (q_pop),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `HDT_ASSERT_IMPL(a_no_accept_in_init, s_tvalid && s_tready, status.init_done, "early word")
    `HDT_ASSERT_IMPL(a_no_result_in_init, !status.init_done, !m_tvalid && !q_valid, "early result")
    `HDT_ASSERT_IMPL(a_pop_when_idle, q_pop, q_valid && !status.busy, "pop while busy")
    `HDT_ASSERT_NEXT(a_init_stays_done, status.init_done, status.init_done, "init restarted")

endmodule

// ----- src/hdt_front.sv -----
// ----------------------------------------------------------------------------
// Huffman decode table front end
// Accepts operation words and turns them into lookup, fill or reject commands.
// ----------------------------------------------------------------------------
module hdt_front #(
    parameter int CODE_BITS   = hdt_pkg::CODE_BITS_DEF,
    parameter int SYMBOL_BITS = hdt_pkg::SYMBOL_BITS_DEF,
    parameter int CMD_W       = 2 + 2 * CODE_BITS + 1 + hdt_pkg::LEN_W + SYMBOL_BITS
) (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // key_or_code[9:0], code_length[13:10], symbol[21:14], zero fill
    input  logic [hdt_pkg::S_TDATA_W-1:0] s_tdata,
    // func[1:0]
    input  logic [hdt_pkg::FUNC_W-1:0]    s_tuser,
    input  hdt_pkg::status_t              status,
    output logic                          q_push,
    output logic [CMD_W-1:0]              q_data,
    input  logic                          q_ready
);

    typedef struct packed {
        hdt_pkg::kind_t                kind;
        logic [CODE_BITS-1:0]          addr;
        logic [CODE_BITS:0]            step;
        logic [hdt_pkg::LEN_W-1:0]     len;
        logic [SYMBOL_BITS-1:0]        sym;
    } cmd_t;

    logic [hdt_pkg::KEY_W-1:0]    key;
    logic [hdt_pkg::LEN_W-1:0]    len;
    logic [hdt_pkg::SYM_IO_W-1:0] sym_in;
    logic [CODE_BITS-1:0]         idx;
    logic [CODE_BITS-1:0]         code_mask;
    hdt_pkg::func_t               func;
    cmd_t                         cmd;

    assign key    = s_tdata[hdt_pkg::KEY_W-1:0];
    assign len    = s_tdata[hdt_pkg::KEY_W +: hdt_pkg::LEN_W];
    assign sym_in = s_tdata[hdt_pkg::KEY_W + hdt_pkg::LEN_W +: hdt_pkg::SYM_IO_W];
    assign func   = hdt_pkg::func_t'(s_tuser);
    assign idx    = CODE_BITS'(key);

    assign code_mask = (CODE_BITS'(1) << len) - CODE_BITS'(1);

    assign s_tready = q_ready && status.init_done;
    assign q_push   = s_tvalid && s_tready;
    assign q_data   = cmd;

    always_comb
    begin
        cmd.kind = hdt_pkg::KIND_FILL;
        cmd.addr = idx;
        cmd.step = (CODE_BITS + 1)'(1) << CODE_BITS;
        cmd.len  = len;
        cmd.sym  = SYMBOL_BITS'(sym_in);
        unique case (func)
            hdt_pkg::FUNC_LOOKUP:
            begin
                cmd.kind = hdt_pkg::KIND_LOOKUP;
            end
            hdt_pkg::FUNC_INSERT:
            begin
                if (len == '0 || int'(len) > CODE_BITS)
                begin
                    cmd.kind = hdt_pkg::KIND_REJECT;
                end
                cmd.addr = idx & code_mask;
                cmd.step = (CODE_BITS + 1)'(1) << len;
            end
            hdt_pkg::FUNC_WRITE:
            begin
                cmd.kind = hdt_pkg::KIND_FILL;
            end
            hdt_pkg::FUNC_CLEAR:
            begin
                cmd.addr = '0;
                cmd.step = (CODE_BITS + 1)'(1);
                cmd.len  = '0;
                cmd.sym  = '0;
            end
        endcase
    end

endmodule

// ----- src/hdt_queue.sv -----
// ----------------------------------------------------------------------------
// Huffman decode table command queue
// Short FIFO between front end and table engine.
// ----------------------------------------------------------------------------
module hdt_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             push_ready,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             pop_valid
);

    localparam int DEPTH = hdt_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- src/hdt_back.sv -----
// ----------------------------------------------------------------------------
// Huffman decode table engine
// Holds the table memory, runs lookups and fill sweeps, drives result words.
// ----------------------------------------------------------------------------
module hdt_back #(
    parameter int CODE_BITS   = hdt_pkg::CODE_BITS_DEF,
    parameter int SYMBOL_BITS = hdt_pkg::SYMBOL_BITS_DEF,
    parameter int CMD_W       = 2 + 2 * CODE_BITS + 1 + hdt_pkg::LEN_W + SYMBOL_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  logic [CMD_W-1:0]              q_data,
    output logic                          q_pop,
    output hdt_pkg::status_t              status,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // found[0], out_symbol[8:1], out_length[12:9], accepted[13], zero fill
    output logic [hdt_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int LEN_W   = hdt_pkg::LEN_W;
    localparam int ENTRY_W = LEN_W + SYMBOL_BITS;
    localparam int DEPTH   = 2 ** CODE_BITS;
    localparam int PAD_W   = hdt_pkg::M_TDATA_W - 2 - LEN_W - hdt_pkg::SYM_IO_W;

    typedef struct packed {
        hdt_pkg::kind_t                kind;
        logic [CODE_BITS-1:0]          addr;
        logic [CODE_BITS:0]            step;
        logic [LEN_W-1:0]              len;
        logic [SYMBOL_BITS-1:0]        sym;
    } cmd_t;

    cmd_t                        cmd;
    logic [ENTRY_W-1:0]          mem [DEPTH];
    logic [ENTRY_W-1:0]          rd_data_reg;
    logic                        rd_en;
    logic                        mem_we;
    logic [CODE_BITS:0]          sweep_sum;
    logic                        out_free;
    logic [LEN_W-1:0]            rd_len;

    hdt_pkg::state_t             state_reg, state_next;
    logic [CODE_BITS:0]          addr_reg, addr_next;
    logic [CODE_BITS:0]          step_reg, step_next;
    logic [LEN_W-1:0]            len_reg, len_next;
    logic [SYMBOL_BITS-1:0]      sym_reg, sym_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_found_reg, out_found_next;
    logic [hdt_pkg::SYM_IO_W-1:0] out_sym_reg, out_sym_next;
    logic [LEN_W-1:0]            out_len_reg, out_len_next;
    logic                        out_acc_reg, out_acc_next;

    assign cmd       = cmd_t'(q_data);
    assign out_free  = !out_valid_reg || m_tready;
    assign sweep_sum = addr_reg + step_reg;
    assign rd_len    = rd_data_reg[ENTRY_W-1 -: LEN_W];

    assign status.init_done = state_reg != hdt_pkg::ST_INIT;
    assign status.busy      = state_reg != hdt_pkg::ST_IDLE;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {PAD_W'(0), out_acc_reg, out_len_reg, out_sym_reg, out_found_reg};

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        step_next      = step_reg;
        len_next       = len_reg;
        sym_next       = sym_reg;
        out_valid_next = out_valid_reg;
        out_found_next = out_found_reg;
        out_sym_next   = out_sym_reg;
        out_len_next   = out_len_reg;
        out_acc_next   = out_acc_reg;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        mem_we         = 1'b0;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            hdt_pkg::ST_INIT, hdt_pkg::ST_FILL:
            begin
                mem_we    = 1'b1;
                addr_next = sweep_sum;
                if (sweep_sum[CODE_BITS])
                begin
                    state_next = hdt_pkg::ST_IDLE;
                end
            end
            hdt_pkg::ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    unique case (cmd.kind)
                        hdt_pkg::KIND_LOOKUP:
                        begin
                            rd_en      = 1'b1;
                            state_next = hdt_pkg::ST_READ;
                        end
                        hdt_pkg::KIND_FILL:
                        begin
                            addr_next      = {1'b0, cmd.addr};
                            step_next      = cmd.step;
                            len_next       = cmd.len;
                            sym_next       = cmd.sym;
                            out_valid_next = 1'b1;
                            out_found_next = 1'b0;
                            out_sym_next   = '0;
                            out_len_next   = '0;
                            out_acc_next   = 1'b1;
                            state_next     = hdt_pkg::ST_FILL;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_found_next = 1'b0;
                            out_sym_next   = '0;
                            out_len_next   = '0;
                            out_acc_next   = 1'b0;
                        end
                    endcase
                end
            end
            hdt_pkg::ST_READ:
            begin
                out_valid_next = 1'b1;
                out_found_next = rd_len != '0;
                out_sym_next   = (rd_len != '0)
                               ? hdt_pkg::SYM_IO_W'(rd_data_reg[SYMBOL_BITS-1:0]) : '0;
                out_len_next   = rd_len;
                out_acc_next   = 1'b1;
                state_next     = hdt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hdt_pkg::ST_INIT;
            addr_reg      <= '0;
            step_reg      <= (CODE_BITS + 1)'(1);
            len_reg       <= '0;
            sym_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            step_reg      <= step_next;
            len_reg       <= len_next;
            sym_reg       <= sym_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_found_reg <= out_found_next;
        out_sym_reg   <= out_sym_next;
        out_len_reg   <= out_len_next;
        out_acc_reg   <= out_acc_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr_reg[CODE_BITS-1:0]] <= {len_reg, sym_reg};
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[cmd.addr];
        end
    end

endmodule
